/* hdl/ssd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared widths and request codes for the sorted set difference core.
// ----------------------------------------------------------------------------
package ssd_pkg;

   // element and result count widths
   localparam int DATA_W  = 32;
   localparam int COUNT_W = 6;

   // request command codes
   localparam logic [1:0] CMD_APPEND_A = 2'd0;
   localparam logic [1:0] CMD_APPEND_B = 2'd1;
   localparam logic [1:0] CMD_RUN      = 2'd2;

endpackage

/* hdl/ssd_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_mem
// Single-port-write, single-port-read synchronous RAM with registered read
// data. Contents are undefined until written.
// ----------------------------------------------------------------------------
module ssd_mem import ssd_pkg::*; #(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/sorted_set_difference_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_set_difference_core
// Appends elements to two stores (A, B); a run request merges them with two
// pointers and returns A minus B in merge order, then clears both stores.
// ----------------------------------------------------------------------------
// Appends: busy stays low, so appends go back to back.
// A run: each merge step is a RAM read state (ST_MRD) then a compare and
// write back state (ST_MCMP), at most count_a + count_b steps, then results
// are read out from the store A read port.
// Results stream one per cycle once emission starts; the receiver cannot stall.
// Reset: synchronous, active high; clears counts, drop flag and control state.
// Store contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_set_difference_core import ssd_pkg::*; #(
   parameter int DEPTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_cmd,
   input  logic signed [DATA_W-1:0]  req_value,
   output logic                      rsp_strobe,
   output logic signed [DATA_W-1:0]  rsp_element,
   output logic [COUNT_W-1:0]        rsp_result_count,
   output logic                      rsp_is_empty,
   output logic                      rsp_overflowed,
   output logic                      rsp_last_item
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL = CW'(DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MRD,
      ST_MCMP,
      ST_EMIT,
      ST_FIN
   } state_type;

   state_type         state_ff;
   logic [CW-1:0]     count_a_ff, count_b_ff;
   logic              drop_ff;
   logic [CW-1:0]     ia_ff, ib_ff, n_ff, k_ff;
   logic              strobe_ff, empty_ff, last_ff;

   logic              a_wr_en, b_wr_en;
   logic [AW-1:0]     a_wr_addr, a_rd_addr;
   logic [DATA_W-1:0] a_wr_data, a_rd_data, b_rd_data;
   logic              accept;
   logic              b_live, heads_eq, a_less;
   logic              emit_last;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // merge decision on registered RAM outputs
   assign b_live    = (ib_ff < count_b_ff);
   assign heads_eq  = (a_rd_data == b_rd_data);
   assign a_less    = !b_live || ($signed(a_rd_data) < $signed(b_rd_data));
   assign emit_last = (CW'(k_ff + 1'b1) == n_ff);

   // store A port muxing: append in idle, compaction write during merge
   always_comb begin
      a_wr_en   = 1'b0;
      a_wr_addr = count_a_ff[AW-1:0];
      a_wr_data = req_value;
      if (accept && (req_cmd == CMD_APPEND_A) && (count_a_ff < FULL)) begin
         a_wr_en = 1'b1;
      end else if ((state_ff == ST_MCMP) && !(b_live && heads_eq) && a_less) begin
         a_wr_en   = 1'b1;
         a_wr_addr = n_ff[AW-1:0];
         a_wr_data = a_rd_data;
      end
      a_rd_addr = (state_ff == ST_EMIT) ? k_ff[AW-1:0] : ia_ff[AW-1:0];
   end

   assign b_wr_en = accept && (req_cmd == CMD_APPEND_B) && (count_b_ff < FULL);

   ssd_mem #(.DEPTH(DEPTH), .ADDR_W(AW)) u_store_a (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (a_wr_addr),
      .wr_data (a_wr_data),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   ssd_mem #(.DEPTH(DEPTH), .ADDR_W(AW)) u_store_b (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (count_b_ff[AW-1:0]),
      .wr_data (req_value),
      .rd_addr (ib_ff[AW-1:0]),
      .rd_data (b_rd_data)
   );

   // control state machine with registered result flags
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_a_ff <= '0;
         count_b_ff <= '0;
         drop_ff    <= 1'b0;
         ia_ff      <= '0;
         ib_ff      <= '0;
         n_ff       <= '0;
         k_ff       <= '0;
         strobe_ff  <= 1'b0;
         empty_ff   <= 1'b0;
         last_ff    <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  case (req_cmd)
                     CMD_APPEND_A: begin
                        if (count_a_ff < FULL) count_a_ff <= CW'(count_a_ff + 1'b1);
                        else                   drop_ff    <= 1'b1;
                     end
                     CMD_APPEND_B: begin
                        if (count_b_ff < FULL) count_b_ff <= CW'(count_b_ff + 1'b1);
                        else                   drop_ff    <= 1'b1;
                     end
                     CMD_RUN: begin
                        ia_ff    <= '0;
                        ib_ff    <= '0;
                        n_ff     <= '0;
                        state_ff <= ST_MRD;
                     end
                     default: ;
                  endcase
               end
            end
            // read heads at ia / ib, or finish the merge
            ST_MRD: begin
               if (ia_ff < count_a_ff) begin
                  state_ff <= ST_MCMP;
               end else if (n_ff == '0) begin
                  strobe_ff <= 1'b1;
                  empty_ff  <= 1'b1;
                  last_ff   <= 1'b1;
                  state_ff  <= ST_FIN;
               end else begin
                  k_ff     <= '0;
                  state_ff <= ST_EMIT;
               end
            end
            // compare heads; picked A elements are compacted to A[n]
            ST_MCMP: begin
               if (b_live && heads_eq) begin
                  ia_ff <= CW'(ia_ff + 1'b1);
                  ib_ff <= CW'(ib_ff + 1'b1);
               end else if (a_less) begin
                  n_ff  <= CW'(n_ff + 1'b1);
                  ia_ff <= CW'(ia_ff + 1'b1);
               end else begin
                  ib_ff <= CW'(ib_ff + 1'b1);
               end
               state_ff <= ST_MRD;
            end
            // stream compacted A[0..n-1], one read per cycle
            ST_EMIT: begin
               strobe_ff <= 1'b1;
               empty_ff  <= 1'b0;
               last_ff   <= emit_last;
               k_ff      <= CW'(k_ff + 1'b1);
               if (emit_last) state_ff <= ST_FIN;
            end
            // final result is on the ports; clear the stores
            ST_FIN: begin
               count_a_ff <= '0;
               count_b_ff <= '0;
               drop_ff    <= 1'b0;
               state_ff   <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // result ports
   assign rsp_strobe       = strobe_ff;
   assign rsp_element      = empty_ff ? '0 : $signed(a_rd_data);
   assign rsp_result_count = COUNT_W'(n_ff);
   assign rsp_is_empty     = empty_ff;
   assign rsp_overflowed   = drop_ff;
   assign rsp_last_item    = last_ff;

   // checks
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> (state_ff != ST_IDLE))
      else $error("result strobe outside a run");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && empty_ff) |-> last_ff)
      else $error("empty result not marked last");

   a_compact_safe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MCMP) |-> (n_ff <= ia_ff))
      else $error("compaction write overtakes read pointer");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_a_ff <= FULL) && (count_b_ff <= FULL))
      else $error("store count beyond depth");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && last_ff) |=> (state_ff == ST_IDLE) && !strobe_ff)
      else $error("run did not end after last result");

endmodule
